/* rtl/nvrc_pkg.sv */
// ----------------------------------------------------------------------------
// nvrc_pkg: shared types and constants of the record checker
// Status and kind codes, the result entry carried to the output queue and the
// byte-wide CRC-16/CCITT-FALSE update.
// ----------------------------------------------------------------------------
package nvrc_pkg;

  localparam int unsigned SEQ_BYTES  = 8;
  localparam int unsigned HDR_BYTES  = 12;
  localparam int unsigned FTR_BYTES  = 2;
  localparam int unsigned MIN_BYTES  = HDR_BYTES + FTR_BYTES;
  localparam logic [15:0] CRC_POLY   = 16'h1021;
  localparam logic [15:0] CRC_INIT   = 16'hFFFF;
  localparam logic [15:0] CRC_TOP    = 16'h8000;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_SHORT     = 3'd1,
    ST_LONG      = 3'd2,
    ST_LEN_MISM  = 3'd3,
    ST_CRC_MISM  = 3'd4
  } status_t;

  typedef enum logic {
    KIND_PAYLOAD = 1'b0,
    KIND_VERDICT = 1'b1
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  payload_byte;
    logic [63:0] sequence_res;
    logic [31:0] payload_length;
    status_t     status;
    logic        run_end;
  } res_t;

  typedef struct packed {
    logic [1:0] n;
    res_t       first;
    res_t       second;
  } core_out_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] r;
    r = c ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if ((r & CRC_TOP) != 16'h0000) begin
        r = (r << 1) ^ CRC_POLY;
      end else begin
        r = r << 1;
      end
    end
    return r;
  endfunction

endpackage

/* rtl/nvrc_core.sv */
// ----------------------------------------------------------------------------
// nvrc_core: record state and per-beat checking
// Holds the delay line, byte count, running CRC and header fields, and forms
// the payload and verdict results of the beat in the input register.
// ----------------------------------------------------------------------------
module nvrc_core import nvrc_pkg::*; #(
  parameter int unsigned MAX_RECORD_BYTES = 65536
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  logic [7:0] data,
  input  logic       last,
  output core_out_t  co
);

  localparam int unsigned CNT_W = $clog2(MAX_RECORD_BYTES + 2);
  localparam logic [CNT_W-1:0] MAX_CNT   = CNT_W'(MAX_RECORD_BYTES);
  localparam logic [CNT_W-1:0] SEQ_END   = CNT_W'(SEQ_BYTES);
  localparam logic [CNT_W-1:0] HDR_END   = CNT_W'(HDR_BYTES);
  localparam logic [CNT_W-1:0] PAY_START = CNT_W'(MIN_BYTES);
  localparam logic [CNT_W-1:0] MIN_CNT   = CNT_W'(MIN_BYTES);

  logic [7:0]       tail0;
  logic [7:0]       tail1;
  logic [CNT_W-1:0] byte_count;
  logic [15:0]      crc_acc;
  logic [63:0]      seq_reg;
  logic [31:0]      len_reg;

  logic [63:0]      seq_next;
  logic [31:0]      len_next;
  logic [15:0]      crc_next;
  logic [CNT_W-1:0] n;
  logic [CNT_W-1:0] body_len;
  logic             pay_vld;
  status_t          st;
  res_t             pay_res;
  res_t             vrd_res;

  always_comb begin
    seq_next = seq_reg;
    len_next = len_reg;
    if (byte_count < SEQ_END) begin
      seq_next[8*byte_count[2:0] +: 8] = data;
    end else if (byte_count < HDR_END) begin
      len_next[8*byte_count[1:0] +: 8] = data;
    end
    crc_next = (byte_count >= CNT_W'(FTR_BYTES)) ? crc_byte(crc_acc, tail1) : crc_acc;
    pay_vld  = (byte_count >= PAY_START);
    n        = (byte_count <= MAX_CNT) ? byte_count + 1'b1 : byte_count;
    body_len = n - MIN_CNT;

    if (n < MIN_CNT) begin
      st = ST_SHORT;
    end else if (n > MAX_CNT) begin
      st = ST_LONG;
    end else if (len_next != {{(32-CNT_W){1'b0}}, body_len}) begin
      st = ST_LEN_MISM;
    end else if (crc_next != {data, tail0}) begin
      st = ST_CRC_MISM;
    end else begin
      st = ST_OK;
    end

    pay_res                = '0;
    pay_res.kind           = KIND_PAYLOAD;
    pay_res.payload_byte   = tail1;
    pay_res.status         = ST_OK;

    vrd_res                = '0;
    vrd_res.kind           = KIND_VERDICT;
    vrd_res.sequence_res   = seq_next;
    vrd_res.payload_length = len_next;
    vrd_res.status         = st;
    vrd_res.run_end        = 1'b1;

    co.n      = {1'b0, pay_vld} + {1'b0, last};
    co.first  = pay_vld ? pay_res : vrd_res;
    co.second = vrd_res;
  end

  always_ff @(posedge clk) begin
    if (rst || (step && last)) begin
      tail0      <= '0;
      tail1      <= '0;
      byte_count <= '0;
      crc_acc    <= CRC_INIT;
      seq_reg    <= '0;
      len_reg    <= '0;
    end else if (step) begin
      tail1   <= tail0;
      tail0   <= data;
      crc_acc <= crc_next;
      seq_reg <= seq_next;
      len_reg <= len_next;
      if (byte_count <= MAX_CNT) begin
        byte_count <= byte_count + 1'b1;
      end
    end
  end

endmodule

/* rtl/nvrc_out_queue.sv */
// ----------------------------------------------------------------------------
// nvrc_out_queue: two-entry result queue
// Takes up to two results in a cycle and presents the oldest as the output
// beat; the head entry is the output register.
// ----------------------------------------------------------------------------
module nvrc_out_queue import nvrc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic [1:0] push_n,
  input  res_t       first,
  input  res_t       second,
  input  logic       pop,
  output logic [1:0] count,
  output res_t       head
);

  res_t       slot0;
  res_t       slot1;
  res_t       slot0_next;
  res_t       slot1_next;
  logic [1:0] count_next;
  logic [1:0] cnt_pop;

  always_comb begin
    cnt_pop    = count - {1'b0, pop};
    slot0_next = pop ? slot1 : slot0;
    slot1_next = slot1;
    if (push_n != 2'd0) begin
      if (cnt_pop == 2'd0) begin
        slot0_next = first;
      end else if (cnt_pop == 2'd1) begin
        slot1_next = first;
      end
    end
    if (push_n == 2'd2 && cnt_pop == 2'd0) begin
      slot1_next = second;
    end
    count_next = cnt_pop + push_n;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    slot0 <= slot0_next;
    slot1 <= slot1_next;
  end

  assign head = slot0;

endmodule

/* rtl/nv_record_checker.sv */
// ----------------------------------------------------------------------------
// nv_record_checker: stored record checker
// Checks a byte-serial record (sequence, length, payload, CRC footer) and
// emits payload bytes followed by a verdict on the final byte.
// ----------------------------------------------------------------------------
// One byte is accepted every cycle while in_stall is low. A beat sits in
// the input register while the record state and CRC update, then its
// results enter a two-entry queue whose head is the output register;
// results leave one per cycle while out_stall is low. A beat waits in the
// input register until the queue has room for all of its results, so a
// final byte that yields a payload byte and a verdict needs two free
// entries. With the output never stalled the input never waits. A result
// passes through the input register and the queue head register.
module nv_record_checker import nvrc_pkg::*; #(
  parameter int unsigned MAX_RECORD_BYTES = 65536
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        final_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        kind,
  output logic [7:0]  payload_byte,
  output logic [63:0] sequence_res,
  output logic [31:0] payload_length,
  output logic [2:0]  status,
  output logic        run_end
);

  logic       hold_valid;
  logic [7:0] hold_data;
  logic       hold_final;
  logic       take;
  logic       pop;
  logic [1:0] free;
  logic [1:0] q_count;
  logic [1:0] push_n;
  core_out_t  co;
  res_t       head;

  assign pop      = out_valid && !out_stall;
  assign free     = 2'd2 - q_count + {1'b0, pop};
  assign take     = hold_valid && (co.n <= free);
  assign in_stall = hold_valid && !take;
  assign push_n   = take ? co.n : 2'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      hold_valid <= 1'b1;
    end else if (take) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      hold_data  <= data_byte;
      hold_final <= final_byte;
    end
  end

  nvrc_core #(
    .MAX_RECORD_BYTES(MAX_RECORD_BYTES)
  ) u_core (
    .clk  (clk),
    .rst  (rst),
    .step (take),
    .data (hold_data),
    .last (hold_final),
    .co   (co)
  );

  nvrc_out_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push_n (push_n),
    .first  (co.first),
    .second (co.second),
    .pop    (pop),
    .count  (q_count),
    .head   (head)
  );

  assign out_valid      = (q_count != 2'd0);
  assign kind           = head.kind;
  assign payload_byte   = head.payload_byte;
  assign sequence_res   = head.sequence_res;
  assign payload_length = head.payload_length;
  assign status         = head.status;
  assign run_end        = head.run_end;

  a_queue_bound: assert property (@(posedge clk) disable iff (rst) q_count != 2'd3)
    else $error("result queue count out of range");

  a_verdict_ends: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (run_end == (kind == KIND_VERDICT)))
    else $error("run_end does not match result kind");

  a_payload_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && kind == KIND_PAYLOAD) |-> (status == ST_OK && sequence_res == 64'd0
                                             && payload_length == 32'd0))
    else $error("payload beat carries verdict fields");

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid && !in_stall)
    else $error("block not empty after reset");

endmodule
